>>> hdl/tnaa_pkg.sv
package tnaa_pkg;

  // Alarm levels
  localparam logic [1:0] LVL_NORMAL = 2'd0;
  localparam logic [1:0] LVL_WARN   = 2'd1;
  localparam logic [1:0] LVL_CRIT   = 2'd2;

  // Request op codes; the fourth code only re-evaluates the alarm
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_PRESS  = 2'd2;

  // Node numbers that own a stored level
  localparam logic [7:0] NODE_FIRST  = 8'd1;
  localparam logic [7:0] NODE_SECOND = 8'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_BEEP_HALF_PERIOD     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CRITICAL_HOLD_TICKS  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_WINDOW      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WARN_TONE_RELOAD     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CRITICAL_TONE_RELOAD = 3'd4;

  // Register reset values
  localparam logic [9:0]  BEEP_HALF_PERIOD_RST     = 10'd70;
  localparam logic [15:0] CRITICAL_HOLD_TICKS_RST  = 16'd500;
  localparam logic [15:0] DEBOUNCE_WINDOW_RST      = 16'd200;
  localparam logic [15:0] WARN_TONE_RELOAD_RST     = 16'd832;
  localparam logic [15:0] CRITICAL_TONE_RELOAD_RST = 16'd262;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] node_id;
    logic [2:0] node_level;
  } req_t;

  typedef struct packed {
    logic [2:0]  lamp_select;
    logic [1:0]  system_level;
    logic [1:0]  alarm_level;
    logic        beeper_enable;
    logic [15:0] tone_reload;
    logic [15:0] tone_compare;
  } rsp_t;

endpackage

>>> hdl/tnaa_stream_if.sv
interface tnaa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/two_node_alarm_annunciator_core.sv
// Alarm annunciator for two sensor nodes. Requests are ticks, node status
// reports and button presses; each request yields exactly one response with
// the lamp pattern, system and alarm levels, and the beeper tone settings.
// A request is captured in an input register; once the response register is
// free, the node, hold, debounce and beeper state are updated and the response
// register is loaded. One request per cycle is sustained while responses are
// drained; the input register is freed whenever the response register is empty
// or being drained, so a response may wait while the next request is taken.
// Configuration writes take effect on the next edge and must be issued while no
// request is in flight.
module two_node_alarm_annunciator_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [tnaa_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [tnaa_pkg::CfgDataW-1:0]          cfg_data_i,
  tnaa_stream_if.sink                            req_i,
  tnaa_stream_if.source                          rsp_o
);

  // Configuration registers
  logic [9:0]  half_period_q;
  logic [15:0] hold_ticks_q;
  logic [15:0] debounce_q;
  logic [15:0] warn_reload_q;
  logic [15:0] crit_reload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= tnaa_pkg::BEEP_HALF_PERIOD_RST;
      hold_ticks_q  <= tnaa_pkg::CRITICAL_HOLD_TICKS_RST;
      debounce_q    <= tnaa_pkg::DEBOUNCE_WINDOW_RST;
      warn_reload_q <= tnaa_pkg::WARN_TONE_RELOAD_RST;
      crit_reload_q <= tnaa_pkg::CRITICAL_TONE_RELOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tnaa_pkg::REG_BEEP_HALF_PERIOD:     half_period_q <= cfg_data_i[9:0];
        tnaa_pkg::REG_CRITICAL_HOLD_TICKS:  hold_ticks_q  <= cfg_data_i;
        tnaa_pkg::REG_DEBOUNCE_WINDOW:      debounce_q    <= cfg_data_i;
        tnaa_pkg::REG_WARN_TONE_RELOAD:     warn_reload_q <= cfg_data_i;
        tnaa_pkg::REG_CRITICAL_TONE_RELOAD: crit_reload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: response register drains, input register refills behind it
  logic          in_valid_q;
  tnaa_pkg::req_t in_q;
  logic          out_valid_q;
  tnaa_pkg::rsp_t out_q;
  logic          out_free;
  logic          advance;

  assign out_free      = !out_valid_q || rsp_o.ready;
  assign advance       = in_valid_q && out_free;
  assign req_i.ready   = !in_valid_q || out_free;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.payload;
    end
  end

  // Alarm state
  logic [1:0]  first_lvl_q, first_lvl_d;
  logic [1:0]  second_lvl_q, second_lvl_d;
  logic [1:0]  comb_lvl_q, comb_lvl_d;
  logic [1:0]  last_alarm_q, last_alarm_d;
  logic        phase_on_q, phase_on_d;
  logic [9:0]  beep_el_q, beep_el_d;
  logic [15:0] hold_q, hold_d;
  logic [15:0] press_el_q, press_el_d;
  logic [1:0]  rpt_lvl;
  logic [1:0]  alarm_lvl;
  logic [15:0] reload;
  logic [16:0] reload_sum;
  tnaa_pkg::rsp_t rsp_d;

  // Apply the request, then evaluate the alarm
  always_comb begin
    first_lvl_d  = first_lvl_q;
    second_lvl_d = second_lvl_q;
    comb_lvl_d   = comb_lvl_q;
    last_alarm_d = last_alarm_q;
    phase_on_d   = phase_on_q;
    beep_el_d    = beep_el_q;
    hold_d       = hold_q;
    press_el_d   = press_el_q;
    rpt_lvl      = (in_q.node_level > 3'(tnaa_pkg::LVL_CRIT)) ? tnaa_pkg::LVL_CRIT
                                                               : in_q.node_level[1:0];

    case (in_q.op)
      tnaa_pkg::OP_TICK: begin
        if (beep_el_q != '1) beep_el_d = beep_el_q + 10'd1;
        if (press_el_q != '1) press_el_d = press_el_q + 16'd1;
        if (hold_q != '0) hold_d = hold_q - 16'd1;
      end
      tnaa_pkg::OP_REPORT: begin
        if (in_q.node_id == tnaa_pkg::NODE_FIRST) first_lvl_d = rpt_lvl;
        else if (in_q.node_id == tnaa_pkg::NODE_SECOND) second_lvl_d = rpt_lvl;
        comb_lvl_d = (first_lvl_d > second_lvl_d) ? first_lvl_d : second_lvl_d;
      end
      tnaa_pkg::OP_PRESS: begin
        if (press_el_q > debounce_q) begin
          press_el_d = '0;
          comb_lvl_d = (comb_lvl_q >= tnaa_pkg::LVL_CRIT) ? tnaa_pkg::LVL_NORMAL
                                                          : comb_lvl_q + 2'd1;
        end
      end
      default: ;
    endcase

    // Critical hold
    if (comb_lvl_d == tnaa_pkg::LVL_CRIT) hold_d = hold_ticks_q;
    alarm_lvl = (hold_d != '0) ? tnaa_pkg::LVL_CRIT : comb_lvl_d;

    // Restart the beeper on a level change
    if (alarm_lvl != last_alarm_q) begin
      last_alarm_d = alarm_lvl;
      phase_on_d   = 1'b0;
      beep_el_d    = '1;
    end

    // Toggle the beeper phase each half period
    if (alarm_lvl == tnaa_pkg::LVL_NORMAL) begin
      phase_on_d = 1'b0;
    end else if (beep_el_d >= half_period_q) begin
      phase_on_d = !phase_on_d;
      beep_el_d  = '0;
    end

    // Build the response
    reload = '0;
    if (phase_on_d) begin
      reload = (alarm_lvl == tnaa_pkg::LVL_CRIT) ? crit_reload_q : warn_reload_q;
    end
    reload_sum          = {1'b0, reload} + 17'd1;
    rsp_d.lamp_select   = 3'(3'b001 << comb_lvl_d);
    rsp_d.system_level  = comb_lvl_d;
    rsp_d.alarm_level   = alarm_lvl;
    rsp_d.beeper_enable = phase_on_d;
    rsp_d.tone_reload   = reload;
    rsp_d.tone_compare  = phase_on_d ? reload_sum[16:1] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_lvl_q  <= tnaa_pkg::LVL_NORMAL;
      second_lvl_q <= tnaa_pkg::LVL_NORMAL;
      comb_lvl_q   <= tnaa_pkg::LVL_NORMAL;
      last_alarm_q <= tnaa_pkg::LVL_NORMAL;
      phase_on_q   <= 1'b0;
      beep_el_q    <= '1;
      hold_q       <= '0;
      press_el_q   <= '1;
    end else if (advance) begin
      first_lvl_q  <= first_lvl_d;
      second_lvl_q <= second_lvl_d;
      comb_lvl_q   <= comb_lvl_d;
      last_alarm_q <= last_alarm_d;
      phase_on_q   <= phase_on_d;
      beep_el_q    <= beep_el_d;
      hold_q       <= hold_d;
      press_el_q   <= press_el_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= rsp_d;
    end
  end

  // Checks
  a_lamp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot(out_q.lamp_select))
    else $error("lamp pattern not one-hot");

  a_silent_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.beeper_enable) |->
      (out_q.tone_reload == '0 && out_q.tone_compare == '0))
    else $error("tone settings nonzero while silent");

  a_crit_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.system_level == tnaa_pkg::LVL_CRIT) |->
      out_q.alarm_level == tnaa_pkg::LVL_CRIT)
    else $error("critical system level without critical alarm");

  a_alarm_ge_sys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.alarm_level >= out_q.system_level)
    else $error("alarm level below system level");

  a_normal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.alarm_level == tnaa_pkg::LVL_NORMAL) |-> !out_q.beeper_enable)
    else $error("beeper on at normal alarm level");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> ($stable(comb_lvl_q) && $stable(hold_q) && $stable(phase_on_q)))
    else $error("alarm state moved without a request");

endmodule

>>> test/tb.sv
module tb;

  // Spare op code: only re-evaluates the alarm
  localparam logic [1:0] OP_REEVAL = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_REPORTED  = 10;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [tnaa_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [tnaa_pkg::CfgDataW-1:0] cfg_data;

  tnaa_stream_if #(.payload_t(tnaa_pkg::req_t)) req_if ();
  tnaa_stream_if #(.payload_t(tnaa_pkg::rsp_t)) rsp_if ();

  two_node_alarm_annunciator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Register copies
  logic [9:0]  half_period;
  logic [15:0] hold_ticks;
  logic [15:0] debounce_ticks;
  logic [15:0] warn_reload;
  logic [15:0] crit_reload;

  // Annunciator state copy
  logic [1:0]  node1_lvl;
  logic [1:0]  node2_lvl;
  logic [1:0]  sys_lvl;
  logic [1:0]  alarm_lvl;
  logic        tone_on;
  logic [9:0]  beep_cnt;
  logic [15:0] hold_cnt;
  logic [15:0] press_cnt;

  tnaa_pkg::req_t pending_req_q[$];
  tnaa_pkg::rsp_t expected_rsp_q[$];
  int unsigned queued_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned rsp_seen_cnt  = 0;
  int unsigned tone_on_cnt   = 0;
  int unsigned press_ok_cnt  = 0;
  int unsigned settings_cnt  = 1;
  int unsigned cycle_cnt     = 0;
  int unsigned op_seen[4]    = '{default: 0};
  int unsigned idle_pct      = 16;
  logic        req_taken     = 1'b0;

  // Toggle the clock
  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Apply one request to the state copy and return the response it causes
  function automatic tnaa_pkg::rsp_t step_annunciator(tnaa_pkg::req_t r);
    tnaa_pkg::rsp_t o;
    logic [1:0]     lvl;
    logic [1:0]     active;
    logic [16:0]    half_up;
    lvl = (r.node_level > 3'd2) ? tnaa_pkg::LVL_CRIT : r.node_level[1:0];
    case (r.op)
      tnaa_pkg::OP_TICK: begin
        if (beep_cnt != '1) beep_cnt = beep_cnt + 10'd1;
        if (press_cnt != '1) press_cnt = press_cnt + 16'd1;
        if (hold_cnt != '0) hold_cnt = hold_cnt - 16'd1;
      end
      tnaa_pkg::OP_REPORT: begin
        if (r.node_id == tnaa_pkg::NODE_FIRST) node1_lvl = lvl;
        else if (r.node_id == tnaa_pkg::NODE_SECOND) node2_lvl = lvl;
        sys_lvl = (node1_lvl > node2_lvl) ? node1_lvl : node2_lvl;
      end
      tnaa_pkg::OP_PRESS: begin
        if (press_cnt > debounce_ticks) begin
          press_cnt = '0;
          sys_lvl = (sys_lvl >= tnaa_pkg::LVL_CRIT) ? tnaa_pkg::LVL_NORMAL : sys_lvl + 2'd1;
          press_ok_cnt++;
        end
      end
      default: ;
    endcase

    // Latch critical, then restart or advance the beeper
    if (sys_lvl == tnaa_pkg::LVL_CRIT) hold_cnt = hold_ticks;
    active = (hold_cnt != '0) ? tnaa_pkg::LVL_CRIT : sys_lvl;
    if (active != alarm_lvl) begin
      alarm_lvl = active;
      tone_on = 1'b0;
      beep_cnt = '1;
    end
    if (active == tnaa_pkg::LVL_NORMAL) begin
      tone_on = 1'b0;
    end else if (beep_cnt >= half_period) begin
      tone_on = ~tone_on;
      beep_cnt = '0;
    end

    o.lamp_select   = 3'b001 << sys_lvl;
    o.system_level  = sys_lvl;
    o.alarm_level   = active;
    o.beeper_enable = tone_on;
    o.tone_reload   = tone_on ? ((active == tnaa_pkg::LVL_CRIT) ? crit_reload : warn_reload)
                              : 16'd0;
    half_up         = ({1'b0, o.tone_reload} + 17'd1) >> 1;
    o.tone_compare  = half_up[15:0];
    return o;
  endfunction

  // Drive requests and response backpressure
  always @(negedge clk_i) begin : driver
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        if (pending_req_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          req_if.valid   <= 1'b1;
          req_if.payload <= pending_req_q.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= ($urandom_range(99, 0) >= idle_pct);
    end
  end

  // Check responses, then predict for the request taken at this edge
  always @(posedge clk_i) begin : monitor
    tnaa_pkg::rsp_t want;
    tnaa_pkg::rsp_t got;
    if (rst_ni) begin
      req_taken <= req_if.valid && req_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        rsp_seen_cnt++;
        if (got.beeper_enable === 1'b1) tone_on_cnt++;
        if (expected_rsp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTED)
            $display("ERROR: response with nothing outstanding: %p", got);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.lamp_select !== want.lamp_select || got.system_level !== want.system_level
              || got.alarm_level !== want.alarm_level
              || got.beeper_enable !== want.beeper_enable
              || got.tone_reload !== want.tone_reload
              || got.tone_compare !== want.tone_compare) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTED) begin
              $display("ERROR: response %0d lamp %b/%b sys %0d/%0d alarm %0d/%0d",
                       rsp_seen_cnt, want.lamp_select, got.lamp_select, want.system_level,
                       got.system_level, want.alarm_level, got.alarm_level);
              $display("       beep %b/%b reload %0d/%0d compare %0d/%0d (exp/act)",
                       want.beeper_enable, got.beeper_enable, want.tone_reload,
                       got.tone_reload, want.tone_compare, got.tone_compare);
            end
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(step_annunciator(req_if.payload));
        op_seen[req_if.payload.op]++;
        accepted_cnt++;
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [7:0] id, input logic [2:0] lvl);
    tnaa_pkg::req_t r;
    r.op = op;
    r.node_id = id;
    r.node_level = lvl;
    pending_req_q.push_back(r);
    queued_cnt++;
  endtask

  // Mostly well-formed traffic on the two nodes, some noise
  task automatic add_random(input int unsigned n);
    int unsigned pick;
    logic [7:0]  id;
    logic [2:0]  lvl;
    repeat (n) begin
      pick = $urandom_range(99, 0);
      if ($urandom_range(9, 0) == 0) id = 8'($urandom());
      else id = ($urandom_range(1, 0) == 1) ? tnaa_pkg::NODE_FIRST : tnaa_pkg::NODE_SECOND;
      if ($urandom_range(4, 0) == 0) lvl = 3'($urandom());
      else lvl = 3'($urandom_range(2, 0));
      if (pick < 40) push_item(tnaa_pkg::OP_TICK, 8'($urandom()), 3'($urandom()));
      else if (pick < 72) push_item(tnaa_pkg::OP_REPORT, id, lvl);
      else if (pick < 92) push_item(tnaa_pkg::OP_PRESS, 8'($urandom()), 3'($urandom()));
      else push_item(OP_REEVAL, 8'($urandom()), 3'($urandom()));
    end
  endtask

  // Hold until every request has been answered, then let the pipe settle
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [tnaa_pkg::CfgIdxW-1:0] idx,
                           input logic [tnaa_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      tnaa_pkg::REG_BEEP_HALF_PERIOD:     half_period    = data[9:0];
      tnaa_pkg::REG_CRITICAL_HOLD_TICKS:  hold_ticks     = data;
      tnaa_pkg::REG_DEBOUNCE_WINDOW:      debounce_ticks = data;
      tnaa_pkg::REG_WARN_TONE_RELOAD:     warn_reload    = data;
      tnaa_pkg::REG_CRITICAL_TONE_RELOAD: crit_reload    = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] half, input logic [15:0] hold,
                                input logic [15:0] deb, input logic [15:0] warn,
                                input logic [15:0] crit);
    write_reg(tnaa_pkg::REG_BEEP_HALF_PERIOD, half);
    write_reg(tnaa_pkg::REG_CRITICAL_HOLD_TICKS, hold);
    write_reg(tnaa_pkg::REG_DEBOUNCE_WINDOW, deb);
    write_reg(tnaa_pkg::REG_WARN_TONE_RELOAD, warn);
    write_reg(tnaa_pkg::REG_CRITICAL_TONE_RELOAD, crit);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  initial begin
    // Known values on every input before reset releases
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = tnaa_pkg::REG_BEEP_HALF_PERIOD;
    cfg_data       = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;

    half_period    = tnaa_pkg::BEEP_HALF_PERIOD_RST;
    hold_ticks     = tnaa_pkg::CRITICAL_HOLD_TICKS_RST;
    debounce_ticks = tnaa_pkg::DEBOUNCE_WINDOW_RST;
    warn_reload    = tnaa_pkg::WARN_TONE_RELOAD_RST;
    crit_reload    = tnaa_pkg::CRITICAL_TONE_RELOAD_RST;
    node1_lvl      = tnaa_pkg::LVL_NORMAL;
    node2_lvl      = tnaa_pkg::LVL_NORMAL;
    sys_lvl        = tnaa_pkg::LVL_NORMAL;
    alarm_lvl      = tnaa_pkg::LVL_NORMAL;
    tone_on        = 1'b0;
    beep_cnt       = '1;
    hold_cnt       = '0;
    press_cnt      = '1;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, level saturation, foreign nodes, debounce
    push_item(OP_REEVAL, 8'd0, 3'd0);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_FIRST, 3'd1);
    push_item(tnaa_pkg::OP_TICK, 8'd255, 3'd7);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_SECOND, 3'd7);
    push_item(tnaa_pkg::OP_REPORT, 8'd0, 3'd2);
    push_item(tnaa_pkg::OP_REPORT, 8'd255, 3'd0);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_SECOND, 3'd0);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_FIRST, 3'd0);
    push_item(tnaa_pkg::OP_PRESS, 8'd0, 3'd0);
    push_item(tnaa_pkg::OP_PRESS, 8'd255, 3'd7);
    push_item(tnaa_pkg::OP_TICK, 8'd0, 3'd0);
    push_item(tnaa_pkg::OP_TICK, 8'd170, 3'd5);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_FIRST, 3'd3);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_FIRST, 3'd4);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_SECOND, 3'd5);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_SECOND, 3'd6);
    push_item(tnaa_pkg::OP_REPORT, 8'd3, 3'd1);
    push_item(OP_REEVAL, 8'd255, 3'd7);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_FIRST, 3'd0);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_SECOND, 3'd0);
    push_item(tnaa_pkg::OP_TICK, 8'd85, 3'd2);
    wait_drained();

    // Half period and hold of one, no debounce, extreme tone reloads
    apply_settings(16'd1, 16'd1, 16'd0, 16'd1, 16'hFFFF);
    add_random(80);
    wait_drained();

    // Zero half period, hold and reloads; no idling at all here
    idle_pct = 0;
    apply_settings(16'd0, 16'd0, 16'd2, 16'd0, 16'd0);
    add_random(80);
    wait_drained();

    idle_pct = 16;
    apply_settings(16'd3, 16'd8, 16'd5, 16'hFFFF, 16'd1);
    add_random(80);
    wait_drained();

    // Longest half period, hold and debounce: presses never get through
    apply_settings(16'd1023, 16'hFFFF, 16'hFFFF, tnaa_pkg::WARN_TONE_RELOAD_RST,
                   tnaa_pkg::CRITICAL_TONE_RELOAD_RST);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_FIRST, 3'd1);
    repeat (60) push_item(tnaa_pkg::OP_TICK, 8'($urandom()), 3'($urandom()));
    push_item(tnaa_pkg::OP_PRESS, 8'd1, 3'd1);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_SECOND, 3'd2);
    push_item(tnaa_pkg::OP_REPORT, tnaa_pkg::NODE_SECOND, 3'd0);
    add_random(40);
    wait_drained();

    apply_settings(16'd5, 16'd20, 16'd10, 16'($urandom_range(65535, 1)),
                   16'($urandom_range(65535, 1)));
    add_random(90);
    wait_drained();

    $display("Ran %0d requests (%0d ticks, %0d reports, %0d presses, %0d spare) over %0d settings",
             accepted_cnt, op_seen[0], op_seen[1], op_seen[2], op_seen[3], settings_cnt);
    $display("%0d presses got through debounce, %0d responses had the tone running",
             press_ok_cnt, tone_on_cnt);
    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> two_node_alarm_annunciator_core.f
hdl/tnaa_pkg.sv
hdl/tnaa_stream_if.sv
hdl/two_node_alarm_annunciator_core.sv
test/tb.sv
